// ===== design/mcsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcsr_pkg
// Shared types and constants of the midpoint circle span rasterizer.
// ----------------------------------------------------------------------------
package mcsr_pkg;

	// input actions
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_STEP  = 1'b1;

	// configuration register indexes
	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	localparam logic [8:0] WIDTH_RST  = 9'd128;
	localparam logic [8:0] HEIGHT_RST = 9'd64;
	localparam logic [8:0] SCREEN_MAX = 9'd256;

	// span walker slots: 0..7 candidate spans, then the status result
	localparam logic [3:0] IDX_FIRST     = 4'd0;
	localparam logic [3:0] IDX_FILL_LAST = 4'd3;
	localparam logic [3:0] IDX_STATUS    = 4'd8;

	// one octant set plus its status, handed from the step unit to the walker
	typedef struct packed {
		logic [7:0]        cx;
		logic [7:0]        cy;
		logic signed [9:0] x;
		logic signed [9:0] y;
		logic              color;
		logic              filled;
		logic              has_set;
		logic              done;
	} mcsr_item_t;

endpackage : mcsr_pkg
`default_nettype wire

// ===== design/mcsr_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcsr_step
// Circle state and one midpoint iteration per transfer; builds the item.
// ----------------------------------------------------------------------------
module mcsr_step (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                take,
	input  wire logic                action,
	input  wire logic [7:0]          center_x,
	input  wire logic [7:0]          center_y,
	input  wire logic [7:0]          radius,
	input  wire logic                pixel_color,
	input  wire logic                fill_mode,
	output mcsr_pkg::mcsr_item_t     item
);

	logic [7:0]         centre_col_q;
	logic [7:0]         centre_row_q;
	logic signed [9:0]  step_x_q;
	logic signed [9:0]  step_y_q;
	logic signed [13:0] decision_q;
	logic               paint_color_q;
	logic               filled_q;
	logic               active_q;

	logic [7:0]         col_n;
	logic [7:0]         row_n;
	logic signed [9:0]  x_n;
	logic signed [9:0]  y_n;
	logic signed [13:0] d_n;
	logic               color_n;
	logic               filled_n;
	logic               active_n;
	logic               done_n;
	logic               has_set_n;
	logic signed [13:0] x_w;
	logic signed [13:0] y_w;
	logic signed [13:0] diff_w;

	always_comb begin
		col_n     = centre_col_q;
		row_n     = centre_row_q;
		x_n       = step_x_q;
		y_n       = step_y_q;
		d_n       = decision_q;
		color_n   = paint_color_q;
		filled_n  = filled_q;
		active_n  = active_q;
		done_n    = 1'b1;
		has_set_n = 1'b0;
		x_w       = {{4{step_x_q[9]}}, step_x_q};
		y_w       = {{4{step_y_q[9]}}, step_y_q};
		diff_w    = x_w - y_w + 14'sd1;
		if (action == mcsr_pkg::ACT_START) begin
			col_n     = center_x;
			row_n     = center_y;
			x_n       = '0;
			y_n       = {2'b00, radius};
			d_n       = 14'sd3 - $signed({5'b00000, radius, 1'b0});
			color_n   = pixel_color;
			filled_n  = fill_mode;
			active_n  = 1'b1;
			done_n    = 1'b0;
			has_set_n = 1'b1;
		end else if (active_q) begin
			// d > 0: y steps down, d += 4*(x - (y-1)) + 10
			if (decision_q > 14'sd0) begin
				y_n = step_y_q - 10'sd1;
				d_n = decision_q + (diff_w <<< 2) + 14'sd10;
			end else begin
				d_n = decision_q + (x_w <<< 2) + 14'sd6;
			end
			x_n       = step_x_q + 10'sd1;
			has_set_n = 1'b1;
			done_n    = (y_n < x_n);
			active_n  = !done_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_col_q  <= '0;
			centre_row_q  <= '0;
			step_x_q      <= '0;
			step_y_q      <= '0;
			decision_q    <= '0;
			paint_color_q <= 1'b0;
			filled_q      <= 1'b0;
			active_q      <= 1'b0;
		end else if (take) begin
			centre_col_q  <= col_n;
			centre_row_q  <= row_n;
			step_x_q      <= x_n;
			step_y_q      <= y_n;
			decision_q    <= d_n;
			paint_color_q <= color_n;
			filled_q      <= filled_n;
			active_q      <= active_n;
		end
	end

	assign item.cx      = col_n;
	assign item.cy      = row_n;
	assign item.x       = x_n;
	assign item.y       = y_n;
	assign item.color   = color_n;
	assign item.filled  = filled_n;
	assign item.has_set = has_set_n;
	assign item.done    = done_n;

endmodule : mcsr_step
`default_nettype wire

// ===== design/mcsr_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcsr_emit
// Item register, span walker with clipping, and the result register.
// ----------------------------------------------------------------------------
module mcsr_emit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire mcsr_pkg::mcsr_item_t item,
	input  wire logic [8:0]          width_eff,
	input  wire logic [8:0]          height_eff,
	output logic                     item_free,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     is_span,
	output logic [7:0]               span_row,
	output logic [7:0]               span_left,
	output logic [7:0]               span_right,
	output logic                     span_color,
	output logic                     done_res,
	output logic                     last
);

	mcsr_pkg::mcsr_item_t item_s1;
	logic                 item_valid_s1;
	logic [3:0]           idx_q;
	logic                 out_valid_q;

	logic                 out_free;
	logic                 advance;
	logic                 at_status;
	logic [3:0]           idx_next;
	logic signed [10:0]   cx_w, cy_w, x_w, y_w;
	logic signed [10:0]   cxpx, cxmx, cxpy, cxmy, cypx, cymx, cypy, cymy;
	logic signed [10:0]   row_c, lo_c, hi_c, lo_k, hi_k, wm1, h_w;
	logic                 keep;

	assign out_free  = !out_valid_q || out_ready;
	assign advance   = item_valid_s1 && out_free;
	assign at_status = (idx_q == mcsr_pkg::IDX_STATUS);
	assign item_free = !item_valid_s1 || (advance && at_status);

	always_comb begin
		if (item_s1.filled && (idx_q == mcsr_pkg::IDX_FILL_LAST)) begin
			idx_next = mcsr_pkg::IDX_STATUS;
		end else begin
			idx_next = idx_q + 4'd1;
		end
	end

	// signed corner coordinates
	assign cx_w = {3'b000, item_s1.cx};
	assign cy_w = {3'b000, item_s1.cy};
	assign x_w  = {item_s1.x[9], item_s1.x};
	assign y_w  = {item_s1.y[9], item_s1.y};
	assign cxpx = cx_w + x_w;
	assign cxmx = cx_w - x_w;
	assign cxpy = cx_w + y_w;
	assign cxmy = cx_w - y_w;
	assign cypx = cy_w + x_w;
	assign cymx = cy_w - x_w;
	assign cypy = cy_w + y_w;
	assign cymy = cy_w - y_w;

	always_comb begin
		row_c = cypy;
		lo_c  = cxpx;
		hi_c  = cxpx;
		if (item_s1.filled) begin
			case (idx_q[1:0])
				2'd0: begin row_c = cypy; lo_c = cxmx; hi_c = cxpx; end
				2'd1: begin row_c = cymy; lo_c = cxmx; hi_c = cxpx; end
				2'd2: begin row_c = cypx; lo_c = cxmy; hi_c = cxpy; end
				default: begin row_c = cymx; lo_c = cxmy; hi_c = cxpy; end
			endcase
		end else begin
			case (idx_q[2:0])
				3'd0: begin row_c = cypy; lo_c = cxpx; hi_c = cxpx; end
				3'd1: begin row_c = cypy; lo_c = cxmx; hi_c = cxmx; end
				3'd2: begin row_c = cymy; lo_c = cxpx; hi_c = cxpx; end
				3'd3: begin row_c = cymy; lo_c = cxmx; hi_c = cxmx; end
				3'd4: begin row_c = cypx; lo_c = cxpy; hi_c = cxpy; end
				3'd5: begin row_c = cypx; lo_c = cxmy; hi_c = cxmy; end
				3'd6: begin row_c = cymx; lo_c = cxpy; hi_c = cxpy; end
				default: begin row_c = cymx; lo_c = cxmy; hi_c = cxmy; end
			endcase
		end
	end

	// clip: drop empty or off-row spans, clamp columns to the screen
	assign wm1  = $signed({2'b00, width_eff}) - 11'sd1;
	assign h_w  = $signed({2'b00, height_eff});
	assign lo_k = lo_c[10] ? 11'sd0 : lo_c;
	assign hi_k = (hi_c > wm1) ? wm1 : hi_c;
	assign keep = !(lo_c > hi_c) && !row_c[10] && (row_c < h_w) && !(lo_k > hi_k);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			idx_q         <= mcsr_pkg::IDX_STATUS;
			out_valid_q   <= 1'b0;
		end else begin
			if (load) begin
				item_valid_s1 <= 1'b1;
				idx_q <= item.has_set ? mcsr_pkg::IDX_FIRST : mcsr_pkg::IDX_STATUS;
			end else if (advance) begin
				if (at_status) begin
					item_valid_s1 <= 1'b0;
				end else begin
					idx_q <= idx_next;
				end
			end
			if (advance) begin
				out_valid_q <= at_status || keep;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
		end
		if (advance) begin
			if (at_status) begin
				is_span    <= 1'b0;
				span_row   <= '0;
				span_left  <= '0;
				span_right <= '0;
				span_color <= 1'b0;
				done_res   <= item_s1.done;
				last       <= 1'b1;
			end else begin
				is_span    <= 1'b1;
				span_row   <= row_c[7:0];
				span_left  <= lo_k[7:0];
				span_right <= hi_k[7:0];
				span_color <= item_s1.color;
				done_res   <= 1'b0;
				last       <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid_s1 |-> (idx_q <= mcsr_pkg::IDX_STATUS))
		else $error("span walker slot out of range");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> item_free)
		else $error("item register overwritten while busy");
	a_load_held: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> item_valid_s1)
		else $error("loaded item lost");
	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && is_span) |-> (span_left <= span_right && !last))
		else $error("span result malformed");
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !is_span) |-> last)
		else $error("status result without last");
`endif

endmodule : mcsr_emit
`default_nettype wire

// ===== design/midpoint_circle_span_rasterizer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// midpoint_circle_span_rasterizer_core
// Midpoint circle generator emitting clipped outline points or fill spans.
// ----------------------------------------------------------------------------
// Path: the first slot of an item is loaded into the item register, then
//   into the result register once that register is free.
// Throughput: the span walker visits one candidate slot per cycle while the
//   result register is free; an item takes 9 slots in outline mode, 5 in fill
//   mode, 1 for a step with no circle in progress (dropped spans still use their slot).
// Reset (arst_n low, async): circle idle, walker and result register empty,
//   screen 128 x 64.
module midpoint_circle_span_rasterizer_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// configuration writes
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [8:0] cfg_data,
	// input channel
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       action,
	input  wire logic [7:0] center_x,
	input  wire logic [7:0] center_y,
	input  wire logic [7:0] radius,
	input  wire logic       pixel_color,
	input  wire logic       fill_mode,
	// result channel
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            is_span,
	output logic [7:0]      span_row,
	output logic [7:0]      span_left,
	output logic [7:0]      span_right,
	output logic            span_color,
	output logic            done_res,
	output logic            last
);

	logic [8:0]           screen_width_q;
	logic [8:0]           screen_height_q;
	logic [8:0]           width_eff;
	logic [8:0]           height_eff;
	logic                 take;
	logic                 item_free;
	mcsr_pkg::mcsr_item_t item;

	// screen size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= mcsr_pkg::WIDTH_RST;
			screen_height_q <= mcsr_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mcsr_pkg::CFG_WIDTH:  screen_width_q  <= cfg_data;
				mcsr_pkg::CFG_HEIGHT: screen_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// anything past 256 behaves as 256
	assign width_eff  = (screen_width_q > mcsr_pkg::SCREEN_MAX) ?
		mcsr_pkg::SCREEN_MAX : screen_width_q;
	assign height_eff = (screen_height_q > mcsr_pkg::SCREEN_MAX) ?
		mcsr_pkg::SCREEN_MAX : screen_height_q;

	// a new transfer is taken as soon as the walker frees its item register,
	// which may be in the same cycle its status result moves to the output
	assign in_ready = item_free;
	assign take     = in_valid && in_ready;

	// circle state and midpoint iteration, updated on each input transfer
	mcsr_step u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.action      (action),
		.center_x    (center_x),
		.center_y    (center_y),
		.radius      (radius),
		.pixel_color (pixel_color),
		.fill_mode   (fill_mode),
		.item        (item)
	);

	// octant set walker, clipper and result register
	mcsr_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (take),
		.item       (item),
		.width_eff  (width_eff),
		.height_eff (height_eff),
		.item_free  (item_free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.is_span    (is_span),
		.span_row   (span_row),
		.span_left  (span_left),
		.span_right (span_right),
		.span_color (span_color),
		.done_res   (done_res),
		.last       (last)
	);

endmodule : midpoint_circle_span_rasterizer_core
`default_nettype wire

// ===== tb/sv/midpoint_circle_span_rasterizer_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_circle_span_rasterizer_core_test
// Self-checking bench for the midpoint circle span rasterizer. A behavioral
// predictor tracks the circle state and screen size, builds the clipped spans
// and closing status of every transfer, and a checker compares each result
// field by field. Directed circles come first, then random circle sequences
// over several screen sizes, with random idling on both channels.
// ----------------------------------------------------------------------------
module midpoint_circle_span_rasterizer_core_test;
	import mcsr_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_ITEMS  = 200;
	localparam int RANDOM_PHASES = 6;
	localparam int SETTLE_CYCLES = 12;	// walker holds at most 9 slots

	// one result as seen on the result channel
	typedef struct packed {
		logic       is_span;
		logic [7:0] row;
		logic [7:0] col_lo;
		logic [7:0] col_hi;
		logic       color;
		logic       done;
		logic       last;
	} span_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [8:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic action;
	logic [7:0] center_x;
	logic [7:0] center_y;
	logic [7:0] radius;
	logic pixel_color;
	logic fill_mode;
	logic out_valid;
	logic out_ready = 1'b0;
	logic is_span;
	logic [7:0] span_row;
	logic [7:0] span_left;
	logic [7:0] span_right;
	logic span_color;
	logic done_res;
	logic last;

	always #5 clk = ~clk;

	midpoint_circle_span_rasterizer_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.center_x    (center_x),
		.center_y    (center_y),
		.radius      (radius),
		.pixel_color (pixel_color),
		.fill_mode   (fill_mode),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.is_span     (is_span),
		.span_row    (span_row),
		.span_left   (span_left),
		.span_right  (span_right),
		.span_color  (span_color),
		.done_res    (done_res),
		.last        (last)
	);

	// ------------------------------------------------------------------
	// Predictor state: screen size and the circle in progress
	// ------------------------------------------------------------------
	logic [8:0]         scr_w;
	logic [8:0]         scr_h;
	logic [7:0]         circ_cx;
	logic [7:0]         circ_cy;
	logic signed [9:0]  circ_x;
	logic signed [9:0]  circ_y;
	logic signed [13:0] circ_d;
	logic               circ_color;
	logic               circ_fill;
	logic               circ_live;

	span_result_t expected_spans[$];

	// bookkeeping
	int error_count   = 0;
	int items_sent    = 0;
	int random_count  = 0;
	int results_seen  = 0;
	int spans_seen    = 0;
	int circles_ended = 0;
	int cfg_writes    = 0;
	int cycle_count   = 0;

	// idling controls, switched per sequence so some stretches run flat out
	logic send_idle = 1'b0;
	logic sink_idle = 1'b0;
	logic took_result = 1'b0;
	int   sink_wait = 0;

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= 40)
			$display("[%0t] MISMATCH: %s", $time, msg);
	endtask

	// Clip one candidate span against the screen and queue it if anything
	// remains. Row off screen or empty column range drops the span.
	function automatic void push_span(input int row, input int lo, input int hi);
		int w_eff;
		int h_eff;
		span_result_t res;
		w_eff = (scr_w > SCREEN_MAX) ? int'(SCREEN_MAX) : int'(scr_w);
		h_eff = (scr_h > SCREEN_MAX) ? int'(SCREEN_MAX) : int'(scr_h);
		if (lo > hi || row < 0 || row >= h_eff)
			return;
		if (lo < 0)
			lo = 0;
		if (hi > w_eff - 1)
			hi = w_eff - 1;
		if (lo > hi)
			return;
		res = '0;
		res.is_span = 1'b1;
		res.row     = 8'(row);
		res.col_lo  = 8'(lo);
		res.col_hi  = 8'(hi);
		res.color   = circ_color;
		expected_spans.push_back(res);
	endfunction

	// Octant set at the current (x, y): eight points or four fill spans,
	// in the fixed order the walker visits them.
	function automatic void emit_octants();
		int cx;
		int cy;
		int x;
		int y;
		cx = int'(circ_cx);
		cy = int'(circ_cy);
		x  = int'(circ_x);
		y  = int'(circ_y);
		if (circ_fill) begin
			push_span(cy + y, cx - x, cx + x);
			push_span(cy - y, cx - x, cx + x);
			push_span(cy + x, cx - y, cx + y);
			push_span(cy - x, cx - y, cx + y);
		end else begin
			push_span(cy + y, cx + x, cx + x);
			push_span(cy + y, cx - x, cx - x);
			push_span(cy - y, cx + x, cx + x);
			push_span(cy - y, cx - x, cx - x);
			push_span(cy + x, cx + y, cx + y);
			push_span(cy + x, cx - y, cx - y);
			push_span(cy - x, cx + y, cx + y);
			push_span(cy - x, cx - y, cx - y);
		end
	endfunction

	// Expected results of one accepted transfer: the spans, then the status.
	function automatic void rasterize_item(input logic act, input logic [7:0] cx, cy, r,
			input logic col, fill);
		int d_next;
		logic fin;
		span_result_t status;
		if (act == ACT_START) begin
			circ_cx    = cx;
			circ_cy    = cy;
			circ_x     = '0;
			circ_y     = {2'b00, r};
			circ_d     = 14'(3 - 2 * int'(r));
			circ_color = col;
			circ_fill  = fill;
			circ_live  = 1'b1;
			emit_octants();
			fin = 1'b0;
		end else if (circ_live) begin
			if (circ_d > 0) begin
				circ_y = circ_y - 10'sd1;
				d_next = int'(circ_d) + 4 * (int'(circ_x) - int'(circ_y)) + 10;
			end else begin
				d_next = int'(circ_d) + 4 * int'(circ_x) + 6;
			end
			circ_d = 14'(d_next);
			circ_x = circ_x + 10'sd1;
			emit_octants();
			fin = (circ_y < circ_x);
			if (fin)
				circ_live = 1'b0;
		end else begin
			fin = 1'b1;	// step with nothing in progress
		end
		status = '0;
		status.done = fin;
		status.last = 1'b1;
		expected_spans.push_back(status);
	endfunction

	// ------------------------------------------------------------------
	// Stimulus side
	// ------------------------------------------------------------------
	task automatic send_item(input logic act, input logic [7:0] cx, cy, r,
			input logic col, fill);
		int gap;
		gap = send_idle ? $urandom_range(0, 11) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		action      <= act;
		center_x    <= cx;
		center_y    <= cy;
		radius      <= r;
		pixel_color <= col;
		fill_mode   <= fill;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		rasterize_item(act, cx, cy, r, col, fill);
		items_sent++;
	endtask

	// step with junk in the start-only fields
	task automatic send_step();
		send_item(ACT_STEP, 8'($urandom), 8'($urandom), 8'($urandom),
			1'($urandom), 1'($urandom));
	endtask

	task automatic step_until_done();
		while (circ_live)
			send_step();
	endtask

	// drop valid, wait for every expected result, then let the walker settle
	task automatic finish_phase();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_spans.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [8:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == CFG_WIDTH)
			scr_w = val;
		else
			scr_h = val;
		cfg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_screen(input logic [8:0] w, input logic [8:0] h);
		finish_phase();
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
	endtask

	// ------------------------------------------------------------------
	// Result side: random back-pressure and the checker
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (took_result) begin
			took_result = 1'b0;
			sink_wait = sink_idle ? $urandom_range(0, 11) : 0;
		end
		if (sink_wait != 0) begin
			out_ready <= 1'b0;
			sink_wait--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		span_result_t want;
		if (arst_n && out_valid && out_ready) begin
			took_result = 1'b1;
			results_seen++;
			if (is_span)
				spans_seen++;
			if (expected_spans.size() == 0) begin
				report_error($sformatf("unexpected result is_span=%0b row=%0d cols=%0d..%0d",
					is_span, span_row, span_left, span_right));
			end else begin
				want = expected_spans.pop_front();
				if (!want.is_span && want.done)
					circles_ended++;
				if (is_span !== want.is_span)
					report_error($sformatf("is_span %0b, want %0b", is_span, want.is_span));
				if (span_row !== want.row)
					report_error($sformatf("span_row %0d, want %0d", span_row, want.row));
				if (span_left !== want.col_lo)
					report_error($sformatf("span_left %0d, want %0d", span_left, want.col_lo));
				if (span_right !== want.col_hi)
					report_error($sformatf("span_right %0d, want %0d", span_right, want.col_hi));
				if (span_color !== want.color)
					report_error($sformatf("span_color %0b, want %0b", span_color, want.color));
				if (done_res !== want.done)
					report_error($sformatf("done_res %0b, want %0b", done_res, want.done));
				if (last !== want.last)
					report_error($sformatf("last %0b, want %0b", last, want.last));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected",
				cycle_count, expected_spans.size());
			$display("midpoint_circle_span_rasterizer_core_test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Directed tests
	// ------------------------------------------------------------------

	// step before any circle: status only, done set
	task automatic test_idle_step();
		send_step();
	endtask

	// outline point order on a small circle, zero radius duplicates,
	// and a stale step after the circle ended
	task automatic test_outline_order();
		send_item(ACT_START, 8'd40, 8'd30, 8'd3, 1'b1, 1'b0);
		step_until_done();
		send_step();
		send_item(ACT_START, 8'd10, 8'd10, 8'd0, 1'b0, 1'b0);
		step_until_done();
	endtask

	// fill spans; zero radius step gives negative y and some empty spans
	task automatic test_fill_spans();
		send_item(ACT_START, 8'd64, 8'd32, 8'd6, 1'b1, 1'b1);
		step_until_done();
		send_item(ACT_START, 8'd20, 8'd20, 8'd0, 1'b1, 1'b1);
		step_until_done();
	endtask

	// circles crossing the left/top edge and the far corner
	task automatic test_clipping();
		send_item(ACT_START, 8'd0, 8'd0, 8'd20, 1'b1, 1'b1);
		send_step();
		send_step();
		send_item(ACT_START, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
		send_step();
		send_step();
	endtask

	// zero sized, oversized and single pixel screens
	task automatic test_screen_limits();
		set_screen(9'd0, 9'd0);
		send_item(ACT_START, 8'd5, 8'd5, 8'd2, 1'b1, 1'b1);
		set_screen(9'h1FF, 9'h1FF);
		send_item(ACT_START, 8'd255, 8'd0, 8'd255, 1'b1, 1'b1);
		set_screen(9'd1, 9'd1);
		send_item(ACT_START, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
	endtask

	// ------------------------------------------------------------------
	// Random circle sequences
	// ------------------------------------------------------------------
	task automatic run_sequence();
		int kind;
		int sel;
		int steps;
		int cut;
		logic act;
		logic [7:0] r;
		logic [7:0] cx;
		logic [7:0] cy;
		kind = $urandom_range(0, 9);
		send_idle = ($urandom_range(0, 3) != 0);
		sink_idle = ($urandom_range(0, 3) != 0);
		if (kind < 2) begin
			// noise: loose starts and steps, live or not
			repeat ($urandom_range(1, 4)) begin
				act = 1'($urandom_range(0, 1));
				if (act == ACT_START || circ_live)
					random_count++;
				send_item(act, 8'($urandom), 8'($urandom), 8'($urandom),
					1'($urandom), 1'($urandom));
			end
		end else begin
			// well-formed circle: start, then steps to the end or a cut
			sel = $urandom_range(0, 15);
			if (sel == 0)
				r = 8'($urandom_range(128, 255));
			else if (sel < 4)
				r = 8'($urandom_range(25, 127));
			else
				r = 8'($urandom_range(0, 24));
			cx = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
			cy = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
			if (r > 8'd24)
				cut = $urandom_range(1, 12);
			else if ($urandom_range(0, 4) == 0)
				cut = $urandom_range(0, 6);	// abandoned mid-circle
			else
				cut = 1000;
			send_item(ACT_START, cx, cy, r, 1'($urandom), 1'($urandom));
			random_count++;
			steps = 0;
			while (circ_live && steps < cut) begin
				send_step();
				random_count++;
				steps++;
			end
		end
	endtask

	task automatic test_random_circles();
		logic [8:0] widths[RANDOM_PHASES];
		logic [8:0] heights[RANDOM_PHASES];
		widths  = '{WIDTH_RST, 9'd256, 9'h1FF, 9'd1, 9'd256, 9'($urandom_range(1, 256))};
		heights = '{HEIGHT_RST, 9'd256, 9'd300, 9'd256, 9'd1, 9'($urandom_range(1, 256))};
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			set_screen(widths[p], heights[p]);
			while (random_count < (p + 1) * RANDOM_ITEMS / RANDOM_PHASES)
				run_sequence();
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = CFG_WIDTH;
		cfg_data    = '0;
		in_valid    = 1'b0;
		action      = ACT_START;
		center_x    = '0;
		center_y    = '0;
		radius      = '0;
		pixel_color = 1'b0;
		fill_mode   = 1'b0;
		scr_w       = WIDTH_RST;
		scr_h       = HEIGHT_RST;
		circ_cx     = '0;
		circ_cy     = '0;
		circ_x      = '0;
		circ_y      = '0;
		circ_d      = '0;
		circ_color  = 1'b0;
		circ_fill   = 1'b0;
		circ_live   = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part runs flat out, then with idling on both sides
		test_idle_step();
		test_outline_order();
		send_idle = 1'b1;
		sink_idle = 1'b1;
		test_fill_spans();
		test_clipping();
		test_screen_limits();
		test_random_circles();
		finish_phase();

		while (expected_spans.size() != 0) begin
			report_error("expected result never arrived");
			void'(expected_spans.pop_front());
		end

		$display("covered %0d transfers in, %0d results out (%0d spans, %0d circle ends)",
			items_sent, results_seen, spans_seen, circles_ended);
		$display("screen registers written %0d times, %0d mismatches",
			cfg_writes, error_count);
		if (error_count == 0)
			$display("midpoint_circle_span_rasterizer_core_test passed");
		else
			$display("midpoint_circle_span_rasterizer_core_test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
design/mcsr_pkg.sv
design/mcsr_step.sv
design/mcsr_emit.sv
design/midpoint_circle_span_rasterizer_core.sv
tb/sv/midpoint_circle_span_rasterizer_core_test.sv
